### rtl/wlr_pkg.sv
// Shared constants, types and codes of the windowed load regulator.
`default_nettype none

package wlr_pkg;

    localparam int WINDOW_LEN = 20;
    localparam int ARG_BITS   = 30;
    localparam int SAMPLE_MAX = 10000;

    localparam int SMP_W = 14;
    localparam int CFG_W = 14;
    localparam int CNT_W = 6;
    localparam int AVG_W = SMP_W;
    localparam int ARG_W = ARG_BITS + 1;
    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W = $clog2(SAMPLE_MAX * WINDOW_LEN + 1);

    localparam int DIV_K = SUM_W + $clog2(WINDOW_LEN);
    localparam int RCP_W = SUM_W + 2;
    localparam logic [RCP_W-1:0] DIV_RCP =
        RCP_W'(((longint'(1) << DIV_K) + WINDOW_LEN - 1) / WINDOW_LEN);

    localparam int MUL_W = CFG_W + $clog2(WINDOW_LEN + 1);
    localparam int CMP_W = ((MUL_W > SUM_W) ? MUL_W : SUM_W) + 1;
    localparam int REG_W = CFG_W + 2 + $clog2(WINDOW_LEN + 1);
    localparam logic signed [REG_W-1:0] WIN_S = REG_W'(WINDOW_LEN);

    localparam int MAX_RES   = 3;
    localparam int NRES_W    = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W = $clog2(MAX_RES);

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] DEADBAND_RST    = CFG_W'(500);
    localparam logic [CFG_W-1:0] MARGIN_RST      = CFG_W'(300);
    localparam logic [CNT_W-1:0] MAX_WORKERS_RST = CNT_W'(20);

    localparam logic [ARG_W-1:0] LOW_RST  = ARG_W'(1);
    localparam logic [ARG_W-1:0] HIGH_RST = ARG_W'((longint'(1) << ARG_BITS) - 1);
    localparam logic [ARG_W-1:0] BEST_RST = ARG_W'(longint'(1) << ARG_BITS);
    localparam logic [ARG_W-1:0] MID_RST  = ARG_W'(longint'(1) << (ARG_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADBAND    = 2'd0,
        REG_MARGIN      = 2'd1,
        REG_MAX_WORKERS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_REPORT = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        PHASE_WARM = 2'd0,
        PHASE_CAL  = 2'd1,
        PHASE_REG  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_WARM = 3'b001,
        ST_CAL  = 3'b010,
        ST_REG  = 3'b100
    } state_t;

    typedef struct packed {
        act_t             act;
        logic [ARG_W-1:0] arg;
        logic [CNT_W-1:0] cnt;
    } res_t;

    typedef struct packed {
        logic v;
        res_t r;
    } ev_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [NRES_W-1:0]  n;
        logic [AVG_W-1:0]   avg;
        phase_t             phase;
    } bundle_t;

endpackage

`default_nettype wire

### rtl/wlr_in_if.sv
// Sample channel: valid/ready handshake carrying sample and target.
`default_nettype none

interface wlr_in_if
    import wlr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample;
    logic [SMP_W-1:0] target;

    modport source (output valid, sample, target, input ready);
    modport sink (input valid, sample, target, output ready);
endinterface

`default_nettype wire

### rtl/wlr_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
`default_nettype none

interface wlr_out_if
    import wlr_pkg::*;
();
    logic             valid;
    logic             ready;
    act_t             action;
    logic [ARG_W-1:0] worker_argument;
    logic [AVG_W-1:0] average;
    phase_t           phase;
    logic [CNT_W-1:0] active_workers;
    logic             last;

    modport source (output valid, action, worker_argument, average, phase,
                    active_workers, last, input ready);
    modport sink (input valid, action, worker_argument, average, phase,
                  active_workers, last, output ready);
endinterface

`default_nettype wire

### rtl/wlr_window.sv
// Sliding window of samples with running sum and round position.
`default_nettype none

module wlr_window
    import wlr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [SMP_W-1:0] sample,
    output logic      [SUM_W-1:0] sum_new,
    output logic                  full_new
);

    logic [SMP_W-1:0] win_reg [WINDOW_LEN];
    logic [IDX_W-1:0] idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SMP_W-1:0] clamped;

    always_comb
    begin
        clamped  = (sample > SMP_W'(SAMPLE_MAX)) ? SMP_W'(SAMPLE_MAX) : sample;
        sum_new  = sum_reg - SUM_W'(win_reg[idx_reg]) + SUM_W'(clamped);
        full_new = (idx_reg == IDX_W'(WINDOW_LEN - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (take)
        begin
            win_reg[idx_reg] <= clamped;
            sum_reg          <= sum_new;
            idx_reg          <= full_new ? '0 : idx_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/wlr_emit.sv
// Result buffer that hands out the results of one item, one per handshake.
`default_nettype none

module wlr_emit
    import wlr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire bundle_t bundle,
    output logic         free,
    wlr_out_if.source    res
);

    bundle_t                bundle_reg;
    logic                   valid_reg;
    logic [RES_IDX_W-1:0]   idx_reg;
    res_t                   cur;
    logic                   is_last;

    always_comb
    begin
        cur = bundle_reg.res[0];
        for (int k = 1; k < MAX_RES; k++)
        begin
            if (idx_reg == RES_IDX_W'(k))
            begin
                cur = bundle_reg.res[k];
            end
        end
        is_last = (idx_reg == RES_IDX_W'(bundle_reg.n - NRES_W'(1)));
        free    = !valid_reg || (res.ready && is_last);
    end

    assign res.valid           = valid_reg;
    assign res.action          = cur.act;
    assign res.worker_argument = cur.arg;
    assign res.active_workers  = cur.cnt;
    assign res.average         = bundle_reg.avg;
    assign res.phase           = bundle_reg.phase;
    assign res.last            = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && res.ready)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

endmodule

`default_nettype wire

### rtl/windowed_load_regulator_unit.sv
// Top level of the windowed load regulator: window, search and regulation.
//
//  channel | dir | handshake    | carries
//  --------+-----+--------------+------------------------------------------------
//  meas    | in  | valid/ready  | sample, target
//  res     | out | valid/ready  | action, worker_argument, average, phase,
//          |     |              | active_workers, last
//  wr_*    | in  | wr_en only   | wr_index, wr_data (deadband, margin, max_workers)
//
// An item is taken into the window in its accept cycle, registered, and decided
// once the result buffer is free; its 1 to 3 results leave one per cycle while
// res is ready. One item per cycle is taken while items yield a single result
// and res is ready; an item with more results holds the input until all leave.
// Reset clears the window and worker count and resets the search bounds at once.
// A stall on res holds the buffered results and backs up into meas.ready.
`default_nettype none

module windowed_load_regulator_unit
    import wlr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wlr_in_if.sink                    meas,
    wlr_out_if.source                 res,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data
);

    logic [CFG_W-1:0] deadband_reg;
    logic [CFG_W-1:0] margin_reg;
    logic [CNT_W-1:0] max_workers_reg;

    logic                    take;
    logic [SUM_W-1:0]        sum_new;
    logic                    full_new;
    logic signed [SMP_W:0]   diff_lo;
    logic [SMP_W:0]          sum_hi;
    logic signed [REG_W-1:0] lo_new;
    logic signed [REG_W-1:0] hi_new;

    logic                    a_valid_reg;
    logic [SUM_W-1:0]        a_sum_reg;
    logic                    a_full_reg;
    logic signed [REG_W-1:0] a_lo_reg;
    logic signed [REG_W-1:0] a_hi_reg;

    state_t           state_reg;
    state_t           state_next;
    logic [SUM_W-1:0] base_reg;
    logic [SUM_W-1:0] base_next;
    logic [ARG_W-1:0] low_reg;
    logic [ARG_W-1:0] low_next;
    logic [ARG_W-1:0] high_reg;
    logic [ARG_W-1:0] high_next;
    logic [ARG_W-1:0] mid_reg;
    logic [ARG_W-1:0] mid_next;
    logic [ARG_W-1:0] best_reg;
    logic [ARG_W-1:0] best_next;
    logic [CNT_W-1:0] worker_count_reg;
    logic [CNT_W-1:0] worker_count_next;

    logic                     free;
    logic                     b_load;
    bundle_t                  bundle;
    logic [CMP_W-1:0]         marg_w;
    logic                     pass;
    logic [ARG_W-1:0]         mid_dec;
    logic [ARG_W-1:0]         mid_inc;
    logic [ARG_W:0]           mid_pass_sum;
    logic [ARG_W:0]           mid_fail_sum;
    logic                     cont;
    logic                     below;
    logic                     above;
    logic [CNT_W-1:0]         c1;
    ev_t                      ev1;
    ev_t                      ev2;
    logic [SUM_W+RCP_W-1:0]   avg_prod;

    function automatic ev_t start_ev(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] lim,
                                     logic [ARG_W-1:0] arg);
        ev_t e;
        e = '0;
        if (cnt < lim)
        begin
            e.v     = 1'b1;
            e.r.act = ACT_START;
            e.r.arg = arg;
            e.r.cnt = cnt + 1'b1;
        end
        return e;
    endfunction

    function automatic ev_t stop_ev(logic [CNT_W-1:0] cnt);
        ev_t e;
        e = '0;
        if (cnt != '0)
        begin
            e.v     = 1'b1;
            e.r.act = ACT_STOP;
            e.r.cnt = cnt - 1'b1;
        end
        return e;
    endfunction

    function automatic ev_t regulate(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] lim,
                                     logic [ARG_W-1:0] arg, logic lo_hit, logic hi_hit);
        ev_t e;
        e = '0;
        if (lo_hit)
        begin
            e = start_ev(cnt, lim, arg);
        end
        else if (hi_hit)
        begin
            e = stop_ev(cnt);
        end
        return e;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= DEADBAND_RST;
            margin_reg      <= MARGIN_RST;
            max_workers_reg <= MAX_WORKERS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DEADBAND:    deadband_reg    <= wr_data;
                REG_MARGIN:      margin_reg      <= wr_data;
                REG_MAX_WORKERS: max_workers_reg <= wr_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign b_load     = a_valid_reg && free;
    assign take       = meas.valid && meas.ready;
    assign meas.ready = !a_valid_reg || free;

    wlr_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .sample   (meas.sample),
        .sum_new  (sum_new),
        .full_new (full_new)
    );

    always_comb
    begin
        diff_lo = $signed({1'b0, meas.target}) - $signed({1'b0, deadband_reg});
        sum_hi  = {1'b0, meas.target} + {1'b0, deadband_reg};
        lo_new  = REG_W'(diff_lo) * WIN_S;
        hi_new  = $signed(REG_W'(sum_hi)) * WIN_S;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (b_load)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_sum_reg  <= sum_new;
            a_full_reg <= full_new;
            a_lo_reg   <= lo_new;
            a_hi_reg   <= hi_new;
        end
    end

    always_comb
    begin
        marg_w       = CMP_W'(margin_reg) * CMP_W'(WINDOW_LEN);
        pass         = CMP_W'(a_sum_reg) > (CMP_W'(base_reg) + marg_w);
        mid_dec      = mid_reg - 1'b1;
        mid_inc      = mid_reg + 1'b1;
        mid_pass_sum = {1'b0, low_reg} + {1'b0, mid_dec};
        mid_fail_sum = {1'b0, mid_inc} + {1'b0, high_reg};
        below        = $signed(REG_W'(a_sum_reg)) < a_lo_reg;
        above        = $signed(REG_W'(a_sum_reg)) > a_hi_reg;
        avg_prod     = (SUM_W+RCP_W)'(a_sum_reg) * (SUM_W+RCP_W)'(DIV_RCP);

        state_next = state_reg;
        base_next  = base_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        best_next  = best_reg;
        cont       = 1'b0;
        c1         = worker_count_reg;
        ev1        = '0;
        ev2        = '0;

        if (a_full_reg)
        begin
            unique case (state_reg)
                ST_WARM:
                begin
                    base_next  = a_sum_reg;
                    state_next = ST_CAL;
                    ev1        = start_ev(worker_count_reg, max_workers_reg, mid_reg);
                end
                ST_CAL:
                begin
                    if (pass)
                    begin
                        best_next = mid_reg;
                        high_next = mid_dec;
                        mid_next  = mid_pass_sum[ARG_W:1];
                        cont      = (low_reg <= mid_dec);
                    end
                    else
                    begin
                        low_next = mid_inc;
                        mid_next = mid_fail_sum[ARG_W:1];
                        cont     = (mid_inc <= high_reg);
                    end
                    ev1 = stop_ev(worker_count_reg);
                    c1  = ev1.v ? ev1.r.cnt : worker_count_reg;
                    if (cont)
                    begin
                        ev2 = start_ev(c1, max_workers_reg, mid_next);
                    end
                    else
                    begin
                        state_next = ST_REG;
                        ev2 = regulate(c1, max_workers_reg, best_next, below, above);
                    end
                end
                ST_REG:
                begin
                    ev1 = regulate(worker_count_reg, max_workers_reg, best_reg,
                                   below, above);
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        worker_count_next = ev2.v ? ev2.r.cnt : (ev1.v ? ev1.r.cnt : worker_count_reg);

        bundle            = '0;
        bundle.res[0].act = ACT_REPORT;
        bundle.res[0].arg = '0;
        bundle.res[0].cnt = worker_count_reg;
        bundle.res[1]     = ev1.v ? ev1.r : ev2.r;
        bundle.res[2]     = ev2.r;
        bundle.n          = NRES_W'(1) + NRES_W'(ev1.v) + NRES_W'(ev2.v);
        bundle.avg        = AVG_W'(avg_prod >> DIV_K);
        unique case (state_next)
            ST_WARM: bundle.phase = PHASE_WARM;
            ST_CAL:  bundle.phase = PHASE_CAL;
            ST_REG:  bundle.phase = PHASE_REG;
            default: bundle.phase = PHASE_WARM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_WARM;
            base_reg         <= '0;
            low_reg          <= LOW_RST;
            high_reg         <= HIGH_RST;
            mid_reg          <= MID_RST;
            best_reg         <= BEST_RST;
            worker_count_reg <= '0;
        end
        else if (b_load)
        begin
            state_reg        <= state_next;
            base_reg         <= base_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            mid_reg          <= mid_next;
            best_reg         <= best_next;
            worker_count_reg <= worker_count_next;
        end
    end

    wlr_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (b_load),
        .bundle (bundle),
        .free   (free),
        .res    (res)
    );

endmodule

`default_nettype wire

### rtl/wlr_check.sv
// Port-level checks of the result stream, bound to the top level.
`default_nettype none

module wlr_check
    import wlr_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire act_t             res_action,
    input wire logic [ARG_W-1:0] res_arg,
    input wire logic [AVG_W-1:0] res_avg,
    input wire phase_t           res_phase,
    input wire logic [CNT_W-1:0] res_cnt,
    input wire logic             res_last
);

    logic                 res_acc;
    logic [NRES_W-1:0]    seen_reg;

    assign res_acc = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (res_acc)
        begin
            seen_reg <= res_last ? '0 : seen_reg + 1'b1;
        end
    end

    a_first_is_report: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && (seen_reg == '0) |-> res_action == ACT_REPORT)
        else $error("first result of an item is not a report");

    a_at_most_three: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && (seen_reg == NRES_W'(MAX_RES - 1)) |-> res_last)
        else $error("item gave more results than allowed");

    a_arg_only_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_action != ACT_START) |-> res_arg == '0)
        else $error("argument set on a report or stop result");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_action)
            && $stable(res_arg) && $stable(res_avg) && $stable(res_phase)
            && $stable(res_cnt) && $stable(res_last))
        else $error("result changed while stalled");

endmodule

bind windowed_load_regulator_unit wlr_check u_wlr_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_action (res.action),
    .res_arg    (res.worker_argument),
    .res_avg    (res.average),
    .res_phase  (res.phase),
    .res_cnt    (res.active_workers),
    .res_last   (res.last)
);

`default_nettype wire
